### rtl/pfl_pkg.sv
// Shared types and constants for the FIFO/LRU page replacement block.
// Used by pfl_cell and page_replacement_fifo_lru; depends on nothing.
package pfl_pkg;

   localparam int NUM_FRAMES = 64;
   localparam int PAGE_BITS  = 16;
   localparam int AGE_BITS   = 16;

   localparam int IDX_BITS = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CNT_BITS = $clog2(NUM_FRAMES + 1);

   localparam int PAGE_IN_BITS   = 16;
   localparam int FRAME_OUT_BITS = 6;
   localparam int FAULT_BITS     = 32;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 7;

   localparam logic [CSR_INDEX_BITS-1:0] REG_POLICY_MODE   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAMES_IN_USE = 1'd1;

   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   // Partial search result carried from cell to cell along the row.
   typedef struct packed {
      logic                 tok;
      logic                 hit_found;
      logic [IDX_BITS-1:0]  hit_idx;
      logic                 empty_found;
      logic [IDX_BITS-1:0]  empty_idx;
      logic                 best_set;
      logic [IDX_BITS-1:0]  best_idx;
      logic [AGE_BITS-1:0]  best_age;
      logic [PAGE_BITS-1:0] best_page;
      logic [PAGE_BITS-1:0] fifo_page;
      logic                 fifo_valid;
   } chain_type;

   // Update broadcast from the controller to every cell at once.
   typedef struct packed {
      logic                 clr;
      logic                 en;
      logic                 load;
      logic [IDX_BITS-1:0]  slot;
      logic [PAGE_BITS-1:0] page;
   } upd_type;

endpackage

### rtl/pfl_cell.sv
// One frame of the replacement store: page, valid bit and age, plus one
// stage of the search row. Depends on pfl_pkg.
module pfl_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pfl_pkg::IDX_BITS-1:0]  cell_index,
   input  logic [pfl_pkg::CNT_BITS-1:0]  active_count,
   input  logic [pfl_pkg::PAGE_BITS-1:0] query_page,
   input  logic [pfl_pkg::IDX_BITS-1:0]  fifo_slot,
   input  pfl_pkg::upd_type              upd,
   input  pfl_pkg::chain_type            chain_in,
   output pfl_pkg::chain_type            chain_out
);

   logic [pfl_pkg::PAGE_BITS-1:0] page_ff, page_in;
   logic                          valid_ff, valid_in;
   logic [pfl_pkg::AGE_BITS-1:0]  age_ff, age_in;
   pfl_pkg::chain_type            carry_ff, carry_in;
   logic                          active;

   assign active = pfl_pkg::CNT_BITS'(cell_index) < active_count;

   always_comb begin
      carry_in = chain_in;
      if (chain_in.tok && active) begin
         if (valid_ff && page_ff == query_page && !chain_in.hit_found) begin
            carry_in.hit_found = 1'b1;
            carry_in.hit_idx   = cell_index;
         end
         if (!valid_ff && !chain_in.empty_found) begin
            carry_in.empty_found = 1'b1;
            carry_in.empty_idx   = cell_index;
         end
         // Strictly larger age wins, so ties stay with the lower frame.
         if (!chain_in.best_set || age_ff > chain_in.best_age) begin
            carry_in.best_set  = 1'b1;
            carry_in.best_idx  = cell_index;
            carry_in.best_age  = age_ff;
            carry_in.best_page = page_ff;
         end
         if (cell_index == fifo_slot) begin
            carry_in.fifo_page  = page_ff;
            carry_in.fifo_valid = valid_ff;
         end
      end
   end

   always_comb begin
      page_in  = page_ff;
      valid_in = valid_ff;
      age_in   = age_ff;
      if (upd.clr) begin
         page_in  = '0;
         valid_in = 1'b0;
         age_in   = '0;
      end else if (upd.en && active) begin
         if (upd.slot == cell_index) begin
            age_in = '0;
            if (upd.load) begin
               page_in  = upd.page;
               valid_in = 1'b1;
            end
         end else if (valid_ff && age_ff != '1) begin
            age_in = age_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         age_ff   <= '0;
         carry_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         age_ff   <= age_in;
         carry_ff <= carry_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

   assign chain_out = carry_ff;

endmodule

### rtl/page_replacement_fifo_lru.sv
// Top level of the FIFO/LRU page replacement block: controller, registers
// and the row of frame cells. Depends on pfl_pkg and pfl_cell.
//
// Usage: each transfer on the req_ channel carries one page reference. The
// block answers with exactly one transfer on the rsp_ channel: hit flag,
// frame now holding the page, the evicted page if any, and the fault total.
// A set req_start_new_run empties every frame and zeroes the pointer and
// the fault total before the reference is looked up.
// The search token walks the row of NUM_FRAMES cells, one cell per cycle.
// The finished search is registered in res_ff; the frames are then updated
// and the result loaded into the output register together, once that
// register is free. One item is in flight at a time: req_stall is
// high from acceptance until the frames are updated.
// A finished result sits in the output register until taken; while
// rsp_stall holds it there, the block may accept and search the next item,
// and then waits with its update until the output register is free.
// Reset empties all frames, clears the pointer and fault total, and sets
// the policy to FIFO with 64 frames in use. csr_ writes are always taken
// and belong in idle periods only.
module page_replacement_fifo_lru (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pfl_pkg::PAGE_IN_BITS-1:0]    req_page_number,
   input  logic                                req_start_new_run,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic [pfl_pkg::FRAME_OUT_BITS-1:0]  rsp_frame_index,
   output logic                                rsp_evicted_valid,
   output logic [pfl_pkg::PAGE_IN_BITS-1:0]    rsp_evicted_page,
   output logic [pfl_pkg::FAULT_BITS-1:0]      rsp_fault_total,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pfl_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pfl_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DONE} state_type;

   state_type                        state_ff;
   logic                             go_ff;
   logic [pfl_pkg::PAGE_BITS-1:0]    q_page_ff;
   logic [pfl_pkg::IDX_BITS-1:0]     fifo_slot_ff, fifo_slot_in;
   logic [pfl_pkg::IDX_BITS-1:0]     ptr_ff, ptr_eff, ptr_next;
   logic [pfl_pkg::FAULT_BITS-1:0]   fault_ff;
   logic                             mode_ff;
   logic [pfl_pkg::CSR_DATA_BITS-1:0] fiu_ff;
   pfl_pkg::chain_type               res_ff;

   logic                             rsp_valid_ff;
   logic                             rsp_hit_ff, rsp_ev_valid_ff;
   logic [pfl_pkg::FRAME_OUT_BITS-1:0] rsp_frame_ff;
   logic [pfl_pkg::PAGE_IN_BITS-1:0] rsp_ev_page_ff;
   logic [pfl_pkg::FAULT_BITS-1:0]   rsp_fault_ff;

   logic [pfl_pkg::CNT_BITS-1:0]     n_act;
   logic [7:0]                       fiu_wide;
   logic                             req_take, can_out, apply;
   logic                             d_hit, d_ev_valid;
   logic [pfl_pkg::IDX_BITS-1:0]     d_slot;
   logic [pfl_pkg::PAGE_BITS-1:0]    d_ev_page;
   logic [pfl_pkg::FAULT_BITS-1:0]   d_fault;
   logic [pfl_pkg::CNT_BITS-1:0]     slot_plus;
   logic [pfl_pkg::PAGE_BITS+15:0]   page_wide_in, page_wide_out;
   logic [pfl_pkg::IDX_BITS+5:0]     slot_wide;
   logic [pfl_pkg::NUM_FRAMES-1:0]   tok_vec;

   pfl_pkg::upd_type                 upd;
   pfl_pkg::chain_type               chain_w [pfl_pkg::NUM_FRAMES+1];

   // Active frame count: zero acts as one, too large acts as all frames.
   assign fiu_wide = {1'b0, fiu_ff};
   always_comb begin
      if (fiu_ff == '0) begin
         n_act = pfl_pkg::CNT_BITS'(1);
      end else if (fiu_wide > 8'(pfl_pkg::NUM_FRAMES)) begin
         n_act = pfl_pkg::CNT_BITS'(pfl_pkg::NUM_FRAMES);
      end else begin
         n_act = pfl_pkg::CNT_BITS'(fiu_ff);
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign can_out   = !rsp_valid_ff || !rsp_stall;
   assign apply     = (state_ff == ST_DONE) && can_out;
   assign csr_ready = 1'b1;

   assign page_wide_in = {{pfl_pkg::PAGE_BITS{1'b0}}, req_page_number};

   always_comb begin
      ptr_eff = req_start_new_run ? '0 : ptr_ff;
      if (pfl_pkg::CNT_BITS'(ptr_eff) < n_act) begin
         fifo_slot_in = ptr_eff;
      end else begin
         fifo_slot_in = '0;
      end
   end

   // Victim choice from the completed search.
   always_comb begin
      d_hit      = res_ff.hit_found;
      d_slot     = res_ff.hit_idx;
      d_ev_valid = 1'b0;
      d_ev_page  = '0;
      if (!d_hit) begin
         if (mode_ff == pfl_pkg::POLICY_FIFO) begin
            d_slot     = fifo_slot_ff;
            d_ev_valid = res_ff.fifo_valid;
            d_ev_page  = res_ff.fifo_valid ? res_ff.fifo_page : '0;
         end else if (res_ff.empty_found) begin
            d_slot = res_ff.empty_idx;
         end else begin
            d_slot     = res_ff.best_idx;
            d_ev_valid = 1'b1;
            d_ev_page  = res_ff.best_page;
         end
      end
   end

   // Fault total as it stands after this item; held in the output register.
   assign d_fault = (!d_hit && fault_ff != '1) ? fault_ff + 1'b1 : fault_ff;

   assign slot_plus = pfl_pkg::CNT_BITS'(fifo_slot_ff) + 1'b1;
   assign ptr_next  = (slot_plus >= n_act) ? '0 : pfl_pkg::IDX_BITS'(slot_plus);

   assign page_wide_out = {16'd0, d_ev_page};
   assign slot_wide     = {6'd0, d_slot};

   assign upd.clr  = req_take && req_start_new_run;
   assign upd.en   = apply;
   assign upd.load = !d_hit;
   assign upd.slot = d_slot;
   assign upd.page = q_page_ff;

   always_comb begin
      chain_w[0]     = '0;
      chain_w[0].tok = go_ff;
   end

   for (genvar i = 0; i < pfl_pkg::NUM_FRAMES; i++) begin : g_cell
      pfl_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_index   (pfl_pkg::IDX_BITS'(i)),
         .active_count (n_act),
         .query_page   (q_page_ff),
         .fifo_slot    (fifo_slot_ff),
         .upd          (upd),
         .chain_in     (chain_w[i]),
         .chain_out    (chain_w[i+1])
      );
      assign tok_vec[i] = chain_w[i+1].tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         ptr_ff       <= '0;
         fault_ff     <= '0;
         mode_ff      <= pfl_pkg::POLICY_FIFO;
         fiu_ff       <= pfl_pkg::CSR_DATA_BITS'(64);
         rsp_valid_ff <= 1'b0;
      end else begin
         go_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               pfl_pkg::REG_POLICY_MODE:   mode_ff <= csr_wdata[0];
               pfl_pkg::REG_FRAMES_IN_USE: fiu_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (apply) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  go_ff    <= 1'b1;
                  state_ff <= ST_WALK;
                  if (req_start_new_run) begin
                     ptr_ff   <= '0;
                     fault_ff <= '0;
                  end
               end
            end
            ST_WALK: begin
               if (chain_w[pfl_pkg::NUM_FRAMES].tok) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (apply) begin
                  state_ff <= ST_IDLE;
                  fault_ff <= d_fault;
                  if (!d_hit && mode_ff == pfl_pkg::POLICY_FIFO) begin
                     ptr_ff <= ptr_next;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         q_page_ff    <= pfl_pkg::PAGE_BITS'(page_wide_in);
         fifo_slot_ff <= fifo_slot_in;
      end
      if (state_ff == ST_WALK && chain_w[pfl_pkg::NUM_FRAMES].tok) begin
         res_ff <= chain_w[pfl_pkg::NUM_FRAMES];
      end
      if (apply) begin
         rsp_hit_ff      <= d_hit;
         rsp_frame_ff    <= pfl_pkg::FRAME_OUT_BITS'(slot_wide);
         rsp_ev_valid_ff <= d_ev_valid;
         rsp_ev_page_ff  <= pfl_pkg::PAGE_IN_BITS'(page_wide_out);
         rsp_fault_ff    <= d_fault;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_total   = rsp_fault_ff;

   // The search token is never duplicated along the row.
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0({go_ff, tok_vec}))
      else $error("more than one search token in the cell row");

   // The token only reaches the end of the row while a search is running.
   a_tok_in_walk: assert property (@(posedge clock) disable iff (reset)
      chain_w[pfl_pkg::NUM_FRAMES].tok |-> state_ff == ST_WALK)
      else $error("search token left the row outside a search");

   // A hit never reports an eviction.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      apply && d_hit |=> !rsp_evicted_valid && rsp_evicted_page == '0)
      else $error("hit result carries an evicted page");

   // Each unsaturated miss raises the fault total by exactly one.
   a_fault_step: assert property (@(posedge clock) disable iff (reset)
      apply && !d_hit && fault_ff != '1 |=> fault_ff == $past(fault_ff) + 1'b1)
      else $error("fault total did not advance on a miss");

endmodule

### sim/pfl_lookup_checker.sv
// Checker for page_replacement_fifo_lru: keeps its own copy of the frames, ages,
// pointer and fault count, predicts each lookup and compares every result transfer.
// Depends on pfl_pkg; the testbench top instantiates it beside the block.
module pfl_lookup_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [pfl_pkg::PAGE_IN_BITS-1:0]    req_page_number,
   input  logic                                req_start_new_run,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_hit,
   input  logic [pfl_pkg::FRAME_OUT_BITS-1:0]  rsp_frame_index,
   input  logic                                rsp_evicted_valid,
   input  logic [pfl_pkg::PAGE_IN_BITS-1:0]    rsp_evicted_page,
   input  logic [pfl_pkg::FAULT_BITS-1:0]      rsp_fault_total,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [pfl_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pfl_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output int                                  mismatches,
   output int                                  outstanding,
   output int                                  hit_count,
   output int                                  evict_count
);
   import pfl_pkg::*;

   typedef struct packed {
      logic                      hit;
      logic [FRAME_OUT_BITS-1:0] frame;
      logic                      ev_valid;
      logic [PAGE_IN_BITS-1:0]   ev_page;
      logic [FAULT_BITS-1:0]     faults;
   } lookup_t;

   logic [PAGE_BITS-1:0]     frame_pg   [NUM_FRAMES];
   logic                     frame_live [NUM_FRAMES];
   logic [AGE_BITS-1:0]      frame_age  [NUM_FRAMES];
   int                       fifo_ptr;
   logic [FAULT_BITS-1:0]    fault_cnt;
   logic                     policy;
   logic [CSR_DATA_BITS-1:0] frames_cfg;
   lookup_t                  awaited_lookups[$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
      hit_count   = 0;
      evict_count = 0;
   end

   function automatic void clear_frames();
      for (int i = 0; i < NUM_FRAMES; i++) begin
         frame_pg[i]   = '0;
         frame_live[i] = 1'b0;
         frame_age[i]  = '0;
      end
      fifo_ptr  = 0;
      fault_cnt = '0;
   endfunction

   // Handles one page reference against the frame copy and returns the result it causes.
   function automatic lookup_t resolve_reference(logic [PAGE_IN_BITS-1:0] page,
                                                 logic fresh);
      lookup_t r;
      int      n;
      int      slot;
      logic    found;
      logic    empty_seen;
      r          = '0;
      found      = 1'b0;
      empty_seen = 1'b0;
      slot       = 0;
      if (fresh) clear_frames();
      n = (frames_cfg == 0) ? 1 : (frames_cfg > NUM_FRAMES) ? NUM_FRAMES : int'(frames_cfg);
      for (int i = 0; i < n; i++)
         if (!found && frame_live[i] && frame_pg[i] == page) begin
            found = 1'b1;
            slot  = i;
         end
      if (!found) begin
         if (fault_cnt != '1) fault_cnt++;
         if (policy == POLICY_FIFO) begin
            // A pointer left past the active frames by a smaller count restarts at 0.
            slot     = (fifo_ptr < n) ? fifo_ptr : 0;
            fifo_ptr = (slot + 1 >= n) ? 0 : slot + 1;
         end else begin
            for (int i = 0; i < n; i++)
               if (!empty_seen && !frame_live[i]) begin
                  empty_seen = 1'b1;
                  slot       = i;
               end
            if (!empty_seen)
               for (int i = 1; i < n; i++)
                  if (frame_age[i] > frame_age[slot]) slot = i;
         end
         if (frame_live[slot]) begin
            r.ev_valid = 1'b1;
            r.ev_page  = frame_pg[slot];
         end
         frame_pg[slot]   = page;
         frame_live[slot] = 1'b1;
      end
      for (int i = 0; i < n; i++)
         if (i == slot) frame_age[i] = '0;
         else if (frame_live[i] && frame_age[i] != '1) frame_age[i]++;
      r.hit    = found;
      r.frame  = FRAME_OUT_BITS'(slot);
      r.faults = fault_cnt;
      return r;
   endfunction

   task automatic check_field(string field, logic [FAULT_BITS-1:0] want,
                              logic [FAULT_BITS-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      lookup_t want;
      if (reset) begin
         clear_frames();
         policy     = POLICY_FIFO;
         frames_cfg = CSR_DATA_BITS'(64);
         awaited_lookups.delete();
      end else begin
         // Retire the result transfer before queuing a new reference.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_lookups.size() == 0) begin
               $display("%0t: result transfer with nothing expected (frame %0d)",
                        $time, rsp_frame_index);
               mismatches++;
            end else begin
               want = awaited_lookups.pop_front();
               check_field("hit", FAULT_BITS'(want.hit), FAULT_BITS'(rsp_hit));
               check_field("frame_index", FAULT_BITS'(want.frame),
                           FAULT_BITS'(rsp_frame_index));
               check_field("evicted_valid", FAULT_BITS'(want.ev_valid),
                           FAULT_BITS'(rsp_evicted_valid));
               check_field("evicted_page", FAULT_BITS'(want.ev_page),
                           FAULT_BITS'(rsp_evicted_page));
               check_field("fault_total", want.faults, rsp_fault_total);
               if (want.hit) hit_count++;
               if (want.ev_valid) evict_count++;
            end
         end
         if (req_valid && !req_stall)
            awaited_lookups.push_back(resolve_reference(req_page_number, req_start_new_run));
         if (csr_valid && csr_ready)
            case (csr_index)
               REG_POLICY_MODE:   policy = csr_wdata[0];
               REG_FRAMES_IN_USE: frames_cfg = csr_wdata;
               default: ;
            endcase
      end
      outstanding = awaited_lookups.size();
   end

endmodule

### sim/tb_page_replacement_fifo_lru.sv
// Testbench top for page_replacement_fifo_lru: clock, reset, page reference stimulus,
// register writes, result-side stalls and the verdict.
// Depends on pfl_pkg, page_replacement_fifo_lru and pfl_lookup_checker.
module tb_page_replacement_fifo_lru;
   import pfl_pkg::*;

   localparam int SEGMENTS    = 13;
   localparam int SEG_ITEMS   = 100;
   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 500;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [PAGE_IN_BITS-1:0]     req_page_number;
   logic                        req_start_new_run;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic                        rsp_hit;
   logic [FRAME_OUT_BITS-1:0]   rsp_frame_index;
   logic                        rsp_evicted_valid;
   logic [PAGE_IN_BITS-1:0]     rsp_evicted_page;
   logic [FAULT_BITS-1:0]       rsp_fault_total;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]    csr_wdata;

   int   mismatches;
   int   outstanding;
   int   hit_count;
   int   evict_count;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   references_sent = 0;
   logic hold_request = 1'b0;

   page_replacement_fifo_lru dut (.*);

   pfl_lookup_checker lookup_check (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Result side: random stalls, plus one long hold-off so the block backs up.
   initial begin
      int   hold_left;
      logic hold_used;
      hold_left = 0;
      hold_used = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   // Ends the run when no transfer of any kind happens for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_ref(input logic [PAGE_IN_BITS-1:0] page, input logic fresh);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_page_number   <= page;
      req_start_new_run <= fresh;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      references_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Lets every outstanding lookup finish so the registers can be changed safely.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic logic [PAGE_IN_BITS-1:0] pick_page(int pool,
                                                         logic [PAGE_IN_BITS-1:0] base);
      if ($urandom_range(0, 99) < 80)
         return base + PAGE_IN_BITS'($urandom_range(0, pool - 1));
      return PAGE_IN_BITS'($urandom);
   endfunction

   initial begin
      int                       frames;
      int                       active;
      int                       pool;
      int                       directed;
      logic [PAGE_IN_BITS-1:0]  base;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_page_number   = '0;
      req_start_new_run = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // FIFO over four frames: extremes of the page field, a hit and a wrap.
      write_reg(REG_FRAMES_IN_USE, CSR_DATA_BITS'(4));
      send_ref(16'h0000, 1'b0);
      send_ref(16'hFFFF, 1'b0);
      send_ref(16'h1234, 1'b0);
      send_ref(16'h0000, 1'b0);
      send_ref(16'hAAAA, 1'b0);
      send_ref(16'h5555, 1'b0);
      send_ref(16'hFFFF, 1'b0);
      quiesce();
      // The pointer now sits past the single active frame.
      write_reg(REG_FRAMES_IN_USE, CSR_DATA_BITS'(1));
      send_ref(16'h0777, 1'b0);
      send_ref(16'h1234, 1'b0);
      quiesce();
      write_reg(REG_FRAMES_IN_USE, CSR_DATA_BITS'(0));
      send_ref(16'h1234, 1'b0);
      quiesce();
      // Frames 0 and 2 now hold the same page; the lower frame must hit.
      write_reg(REG_FRAMES_IN_USE, CSR_DATA_BITS'(127));
      send_ref(16'h1234, 1'b0);
      send_ref(16'hFFFF, 1'b0);
      quiesce();
      write_reg(REG_POLICY_MODE, CSR_DATA_BITS'(POLICY_LRU));
      write_reg(REG_FRAMES_IN_USE, CSR_DATA_BITS'(3));
      send_ref(16'h0001, 1'b1);
      send_ref(16'h0002, 1'b0);
      send_ref(16'h0003, 1'b0);
      send_ref(16'h0001, 1'b0);
      send_ref(16'h0004, 1'b0);
      send_ref(16'h0003, 1'b0);
      send_ref(16'h0005, 1'b0);
      send_ref(16'h0003, 1'b1);
      directed = references_sent;

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         quiesce();
         send_idle_pct = (seg < 4) ? 20 : (seg < 8) ? 57 : 0;
         recv_idle_pct = (seg < 4) ? 57 : (seg < 8) ? 20 : 0;
         case (seg)
            0:  frames = 4;
            1:  frames = 1;
            2:  frames = 64;
            3:  frames = 8;
            4:  frames = 0;
            5:  frames = 127;
            6:  frames = 16;
            7:  frames = 3;
            8:  frames = 64;
            9:  frames = 2;
            10: frames = 100;
            11: frames = 32;
            default: frames = 5;
         endcase
         write_reg(REG_POLICY_MODE,
                   CSR_DATA_BITS'((seg % 2 == 1) ? POLICY_LRU : POLICY_FIFO));
         write_reg(REG_FRAMES_IN_USE, CSR_DATA_BITS'(frames));
         active = (frames == 0) ? 1 : (frames > NUM_FRAMES) ? NUM_FRAMES : frames;
         // A working set a little larger than the frames gives both hits and faults.
         pool = active + active / 2 + 1;
         base = PAGE_IN_BITS'($urandom);
         if (seg == 9) hold_request <= 1'b1;
         for (int k = 0; k < SEG_ITEMS; k++)
            send_ref(pick_page(pool, base), $urandom_range(0, 99) < 2);
      end
      quiesce();
      repeat (80) @(negedge clock);

      $display("summary: %0d references (%0d directed), %0d hits, %0d evictions",
               references_sent, directed, hit_count, evict_count);
      $display("summary: FIFO and LRU over 0 to 127 frames, with idle and stalled phases");
      if (mismatches == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
